### rtl/core/pug_pkg.sv
`timescale 1ns / 1ps
package pug_pkg;
    localparam logic [31:0] MUL_CONST  = 32'hD256D193;
    localparam logic [31:0] WEYL_CONST = 32'h9E3779B9;

    typedef struct packed {
        logic [31:0] c0;
        logic [31:0] c1;
        logic [31:0] k0;
    } lane_t;
endpackage

### rtl/core/pug_round_cell.sv
`timescale 1ns / 1ps
module pug_round_cell (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            en,
    input  logic            in_valid,
    input  pug_pkg::lane_t  in_lane,
    input  logic [31:0]     k1,
    output logic            out_valid,
    output pug_pkg::lane_t  out_lane
);
    logic [63:0]    prod;
    pug_pkg::lane_t lane_next;
    pug_pkg::lane_t lane_reg;
    logic           valid_reg;

    assign prod = {32'd0, in_lane.c0} * {32'd0, pug_pkg::MUL_CONST};

    always_comb begin
        lane_next.c0 = prod[63:32] ^ in_lane.c1 ^ in_lane.k0;
        lane_next.c1 = prod[31:0];
        lane_next.k0 = in_lane.k0 + pug_pkg::WEYL_CONST + k1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (en) begin
            valid_reg <= in_valid;
        end
        if (en) begin
            lane_reg <= lane_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_lane  = lane_reg;
endmodule

### rtl/core/pug_uniform_conv.sv
`timescale 1ns / 1ps
module pug_uniform_conv (
    input  logic [31:0] c0,
    output logic [31:0] bits
);
    logic [4:0]  p;
    logic [4:0]  s;
    logic [31:0] q;
    logic [31:0] rem;
    logic [31:0] half;
    logic [32:0] m;
    logic [24:0] qr;
    logic [7:0]  bexp;

    // leading one position
    always_comb begin
        p = 5'd0;
        for (int i = 0; i < 32; i++) begin
            if (c0[i]) p = 5'(i);
        end
    end

    always_comb begin
        s    = p - 5'd23;
        q    = c0 >> s;
        rem  = c0 & ((32'd1 << s) - 32'd1);
        half = 32'd1 << (s - 5'd1);
        qr   = q[24:0];
        if (rem > half || (rem == half && q[0])) qr = q[24:0] + 25'd1;
        m    = 33'(qr) << s;
        bits = 32'd0;
        bexp = 8'd0;
        if (c0 == 32'd0) begin
            bits = 32'h2F000000;
        end else if (c0 < 32'h00800000) begin
            // c0 + 0.5 exact, value (2*c0+1)*2^-33, msb at p+1
            bexp = 8'(p) + 8'd1 - 8'd33 + 8'd127;
            bits = {1'b0, bexp, 23'(({c0[22:0], 1'b1}) << (5'd22 - p))};
        end else if (c0 < 32'h01000000) begin
            qr   = {1'b0, c0[23:0]} + {24'd0, c0[0]};
            if (qr[24]) bits = 32'h3B800000;
            else bits = {1'b0, 8'd118, qr[22:0]};
        end else if (m[32]) begin
            bits = 32'h3F800000;
        end else begin
            bexp = 8'(p) + (qr[24] ? 8'd1 : 8'd0) + 8'd95;
            bits = {1'b0, bexp, qr[24] ? 23'd0 : qr[22:0]};
        end
    end
endmodule

### rtl/core/philox_uniform_generator_unit.sv
`timescale 1ns / 1ps
// Philox-2x32-style counter generator: one word per cycle when the output is not stalled,
// through one register per round cell plus an output register; the whole chain stalls while
// the output word is held, so throughput is set by the receiver's ready.
module philox_uniform_generator_unit #(
    parameter int ROUND_COUNT = 10
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [63:0] cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // element_index
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata    // word_lo, word_hi, uniform_bits
);
    logic [63:0]    seed_reg;
    logic           en;
    logic           valid_chain [ROUND_COUNT+1];
    pug_pkg::lane_t lane_chain  [ROUND_COUNT+1];
    logic           out_valid_reg;
    logic [95:0]    out_data_reg;
    logic [31:0]    ubits;

    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seed_reg <= 64'd0;
        end else if (cfg_valid) begin
            seed_reg <= cfg_data;
        end
    end

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    assign valid_chain[0]   = s_tvalid;
    assign lane_chain[0].c0 = s_tdata[31:0];
    assign lane_chain[0].c1 = s_tdata[63:32];
    assign lane_chain[0].k0 = seed_reg[31:0];

    for (genvar g = 0; g < ROUND_COUNT; g++) begin : g_round
        pug_round_cell u_cell (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .en       (en),
            .in_valid (valid_chain[g]),
            .in_lane  (lane_chain[g]),
            .k1       (seed_reg[63:32]),
            .out_valid(valid_chain[g+1]),
            .out_lane (lane_chain[g+1])
        );
    end

    pug_uniform_conv u_conv (
        .c0  (lane_chain[ROUND_COUNT].c0),
        .bits(ubits)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (en) begin
            out_valid_reg <= valid_chain[ROUND_COUNT];
        end
        if (en) begin
            out_data_reg <= {ubits, lane_chain[ROUND_COUNT].c1, lane_chain[ROUND_COUNT].c0};
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
endmodule

### bench/tb_top.sv
`timescale 1ns / 1ps
module tb_top;

    localparam int ROUNDS      = 10;
    localparam int LATENCY     = ROUNDS + 1;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [31:0] FLOAT_ONE = 32'h3F800000;

    typedef struct packed {
        logic [31:0] uniform_bits;
        logic [31:0] word_hi;
        logic [31:0] word_lo;
    } philox_word_t;

    typedef struct {
        logic [63:0] index;
        logic        known;   // set when an expected result is typed in for the row
        philox_word_t result;
    } index_row_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [63:0] cfg_data = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [63:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [95:0] m_tdata;

    philox_uniform_generator_unit #(.ROUND_COUNT(ROUNDS)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    logic [63:0]  seed_shadow = '0;
    philox_word_t expected_words[$];
    int           mismatch_count = 0;
    int           word_count = 0;
    int           unit_count = 0;
    int           ones_seen = 0;
    int           cycle_count = 0;
    int           send_idle_pct = 0;
    int           recv_idle_pct = 0;
    int           recv_hold = 0;

    // float32 of (rne(float(c)) + 0.5) * 2^-32, all integer
    function automatic logic [31:0] uniform_of_word(input logic [31:0] c);
        logic [32:0] m;
        logic [33:0] n;
        logic [31:0] rem, half;
        int msb, sh, ex;
        msb = 0;
        for (int i = 0; i < 32; i++) if (c[i]) msb = i;
        m = {1'b0, c};
        if (msb >= 24) begin
            sh = msb - 23;
            m = {1'b0, c} >> sh;
            rem = c & ((32'd1 << sh) - 1);
            half = 32'd1 << (sh - 1);
            if (rem > half || (rem == half && m[0])) m = m + 1;
            m = m << sh;
        end
        if (m < 33'h800000) begin
            n = {m, 1'b1};
            ex = -33;
        end else if (m < 33'h1000000) begin
            n = m[0] ? m + 1 : m;
            ex = -32;
        end else begin
            n = m;
            ex = -32;
        end
        msb = 0;
        for (int i = 0; i < 34; i++) if (n[i]) msb = i;
        n = (msb <= 23) ? n << (23 - msb) : n >> (msb - 23);
        return {1'b0, 8'(msb + ex + 127), n[22:0]};
    endfunction

    function automatic philox_word_t philox_rounds(input logic [63:0] index,
                                                   input logic [63:0] seed_val);
        logic [31:0] c0, c1, k0;
        logic [63:0] prod;
        philox_word_t w;
        c0 = index[31:0];
        c1 = index[63:32];
        k0 = seed_val[31:0];
        for (int r = 0; r < ROUNDS; r++) begin
            prod = 64'(c0) * 64'(pug_pkg::MUL_CONST);
            c0 = prod[63:32] ^ c1 ^ k0;
            c1 = prod[31:0];
            k0 = k0 + pug_pkg::WEYL_CONST + seed_val[63:32];
        end
        w.word_lo = c0;
        w.word_hi = c1;
        w.uniform_bits = uniform_of_word(c0);
        return w;
    endfunction

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout with %0d words outstanding", expected_words.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // result checker
    always @(posedge aclk) begin
        philox_word_t got, want;
        if (aresetn && m_tvalid && m_tready) begin
            got = m_tdata;
            if (expected_words.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10) $display("unexpected word %h", got);
            end else begin
                want = expected_words.pop_front();
                if (got !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("mismatch: lo %h/%h hi %h/%h uni %h/%h (exp/got)",
                                 want.word_lo, got.word_lo, want.word_hi, got.word_hi,
                                 want.uniform_bits, got.uniform_bits);
                end
                word_count++;
                if (got.uniform_bits == FLOAT_ONE) ones_seen++;
            end
        end
    end

    // receiver: random stalls plus a long hold-off while recv_hold counts down
    always @(negedge aclk) begin
        if (recv_hold > 0) begin
            recv_hold <= recv_hold - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // valid stays up between back-to-back words, drops only while idling
    task automatic send_index(input logic [63:0] index);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= index;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        expected_words.push_back(philox_rounds(index, seed_shadow));
        unit_count++;
        @(negedge aclk);
    endtask

    task automatic drain_words();
        s_tvalid <= 1'b0;
        while (expected_words.size() != 0) @(negedge aclk);
        repeat (LATENCY + 4) @(negedge aclk);
    endtask

    task automatic write_seed(input logic [63:0] value);
        drain_words();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        seed_shadow = value;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic random_batch(input int count);
        logic [63:0] idx;
        for (int i = 0; i < count; i++) begin
            case ($urandom_range(3))
                0: idx = {$urandom, $urandom};
                1: idx = 64'(i);
                2: idx = {32'hFFFFFFFF, $urandom};
                default: idx = {$urandom, 32'(i)};
            endcase
            send_index(idx);
        end
    endtask

    initial begin
        index_row_t rows[$];
        philox_word_t w;
        logic [63:0] seeds[4];
        rows.push_back('{64'h0, 1'b0, '0});
        rows.push_back('{64'hFFFFFFFFFFFFFFFF, 1'b0, '0});
        rows.push_back('{64'h00000000FFFFFFFF, 1'b0, '0});
        rows.push_back('{64'hFFFFFFFF00000000, 1'b0, '0});
        rows.push_back('{64'h5555555555555555, 1'b0, '0});
        rows.push_back('{64'hAAAAAAAAAAAAAAAA, 1'b0, '0});
        rows.push_back('{64'h1, 1'b0, '0});
        rows.push_back('{64'h8000000000000000, 1'b0, '0});

        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // seed left at reset value
        send_idle_pct = 0;
        recv_idle_pct = 0;
        foreach (rows[i]) begin
            if (rows[i].known) begin
                w = philox_rounds(rows[i].index, seed_shadow);
                if (w !== rows[i].result) begin
                    mismatch_count++;
                    $display("table row %0d disagrees", i);
                end
            end
            send_index(rows[i].index);
        end

        // the model's uniform conversion corners are checked directly
        if (uniform_of_word(32'hFFFFFFFF) !== FLOAT_ONE) begin
            mismatch_count++;
            $display("conversion of all-ones word not 1.0");
        end
        if (uniform_of_word(32'h0) !== 32'h2F000000) begin
            mismatch_count++;
            $display("conversion of zero word not 2^-33");
        end

        seeds[0] = 64'hFFFFFFFFFFFFFFFF;
        seeds[1] = {$urandom, $urandom};
        seeds[2] = 64'h00000000FFFFFFFF;
        seeds[3] = 64'h0;

        // sender 37 / receiver 59
        send_idle_pct = 37;
        recv_idle_pct = 59;
        write_seed(seeds[0]);
        random_batch(150);
        write_seed(seeds[1]);
        random_batch(150);

        // long receiver stall while sending on, so the chain backs up
        send_idle_pct = 0;
        recv_idle_pct = 0;
        recv_hold = 200;
        random_batch(60);
        drain_words();

        send_idle_pct = 59;
        recv_idle_pct = 37;
        write_seed(seeds[2]);
        random_batch(250);

        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_seed(seeds[3]);
        random_batch(150);
        write_seed({$urandom, $urandom});
        random_batch(150);

        drain_words();
        $display("sent %0d indices, checked %0d words under 6 seeds, %0d saturated to 1.0",
                 unit_count, word_count, ones_seen);
        if (mismatch_count == 0 && expected_words.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches, %0d left", mismatch_count, expected_words.size());
            $display("RESULT: ERROR");
        end
        $finish;
    end
endmodule
